### rtl/ctl_pkg.sv
// Shared types and constants for the C token lexer.
// Holds the result record, the burst of records one source word produces,
// token kind codes, character codes and the operator tables. No dependencies.
package ctl_pkg;

  localparam int unsigned POS_W = 25;
  localparam int unsigned MAX_SOURCE_BYTES = 16777216;
  // Positions saturate here: the source limit, or the largest 25-bit value.
  localparam logic [POS_W-1:0] POS_CAP =
    (MAX_SOURCE_BYTES < 33554431) ? POS_W'(MAX_SOURCE_BYTES) : '1;

  localparam int unsigned RES_MAX  = 3;
  localparam int unsigned Q_DEPTH  = 8;
  localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W  = Q_PTR_W + 1;
  localparam int unsigned RES_CNT_W = $clog2(RES_MAX + 1);

  // Token kinds.
  localparam logic [5:0] K_IDENT       = 6'd0;
  localparam logic [5:0] K_INT         = 6'd1;
  localparam logic [5:0] K_FLOAT       = 6'd2;
  localparam logic [5:0] K_STRING      = 6'd3;
  localparam logic [5:0] K_CHAR        = 6'd4;
  localparam logic [5:0] K_MULTI_BASE  = 6'd5;
  localparam logic [5:0] K_SINGLE_BASE = 6'd33;
  localparam logic [5:0] K_UNKNOWN     = 6'd57;
  localparam logic [5:0] K_END         = 6'd58;

  // Character codes that have no printable literal form.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Operators of two and three characters, in match priority order.
  // Two-character entries carry a zero third byte.
  localparam int unsigned N_MULTI = 28;
  localparam logic [23:0] MULTI_OPS [N_MULTI] = '{
    {"<", "<", "<"}, {">", ">", ">"}, {".", ".", "."}, {"<", "=", ">"},
    {"-", ">", "*"}, {"-", ">", CH_NUL}, {".", "*", CH_NUL}, {":", ":", CH_NUL},
    {"+", "+", CH_NUL}, {"-", "-", CH_NUL}, {"+", "=", CH_NUL}, {"-", "=", CH_NUL},
    {"*", "=", CH_NUL}, {"/", "=", CH_NUL}, {"%", "=", CH_NUL}, {"=", "=", CH_NUL},
    {"!", "=", CH_NUL}, {"<", "=", CH_NUL}, {">", "=", CH_NUL}, {"&", "&", CH_NUL},
    {"|", "|", CH_NUL}, {"<", "<", "="}, {">", ">", "="}, {"<", "<", CH_NUL},
    {">", ">", CH_NUL}, {"&", "=", CH_NUL}, {"|", "=", CH_NUL}, {"^", "=", CH_NUL}
  };

  localparam int unsigned N_SINGLE = 24;
  localparam logic [7:0] SINGLE_OPS [N_SINGLE] = '{
    "(", ")", "{", "}", "[", "]", ";", ",", ".", "=", "+", "-",
    "*", "/", "%", "<", ">", "!", "&", "|", "^", "~", "?", ":"
  };

  typedef struct packed {
    logic [5:0]       token_kind;
    logic [POS_W-1:0] span_begin;
    logic [POS_W-1:0] span_end;
    logic [POS_W-1:0] start_line;
    logic [POS_W-1:0] start_column;
    logic             run_last;
  } rec_t;

  // All tokens that one source word produces, oldest in slot 0.
  typedef struct packed {
    logic [RES_CNT_W-1:0] cnt;
    rec_t [RES_MAX-1:0]   rec;
  } burst_t;

endpackage

### rtl/ctl_scanner.sv
// Scanner state and the combinational step that folds one source word into it.
// Depends on ctl_pkg for the record types, kind codes and operator tables.
module ctl_scanner (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      data_byte,
  input  logic            end_marker,
  output ctl_pkg::burst_t burst
);
  import ctl_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_HEX, M_INT, M_FRAC, M_EXPS, M_EXPD, M_SUFFIX,
    M_STR, M_CHR, M_LINE, M_BLOCK
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic             flt;
    logic             star;
    logic             esc;
    logic             any;
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] tb;
    logic [POS_W-1:0] tl;
    logic [POS_W-1:0] tc;
  } sc_t;

  // Outcome of one scanner action: new state, bytes eaten, optional token.
  typedef struct packed {
    sc_t        s;
    logic [1:0] used;
    logic       emit;
    logic [5:0] kind;
  } mr_t;

  localparam sc_t SC_RESET = '{
    mode: M_IDLE, flt: 1'b0, star: 1'b0, esc: 1'b0, any: 1'b0,
    off: '0, line: POS_W'(1), col: POS_W'(1),
    tb: '0, tl: POS_W'(1), tc: POS_W'(1)
  };

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_xdigit(logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic id_start(logic [7:0] c);
    return is_alpha(c) || (c == "_");
  endfunction

  function automatic logic id_cont(logic [7:0] c);
    return id_start(c) || is_digit(c);
  endfunction

  function automatic logic [POS_W-1:0] f_sat(logic [POS_W-1:0] v);
    return (v < POS_CAP) ? v + POS_W'(1) : POS_CAP;
  endfunction

  function automatic sc_t f_take(sc_t s, logic [7:0] c);
    sc_t r;
    r = s;
    r.off = f_sat(s.off);
    if (c == CH_NL) begin
      r.line = f_sat(s.line);
      r.col  = POS_W'(1);
    end else begin
      r.col = f_sat(s.col);
    end
    return r;
  endfunction

  function automatic rec_t f_rec(logic [5:0] kind, sc_t s);
    rec_t r;
    r.token_kind   = kind;
    r.span_begin   = s.tb;
    r.span_end     = s.off;
    r.start_line   = s.tl;
    r.start_column = s.tc;
    r.run_last     = 1'b0;
    return r;
  endfunction

  // Number suffix letters; anything else closes the number without eating c.
  function automatic mr_t f_suffix(sc_t s, logic [7:0] c);
    mr_t r;
    r.s = s; r.used = 2'd0; r.emit = 1'b0; r.kind = K_IDENT;
    if ((c == "f") || (c == "F")) begin
      r.s.flt  = 1'b1;
      r.s.mode = M_SUFFIX;
      r.s      = f_take(r.s, c);
      r.used   = 2'd1;
    end else if ((c == "u") || (c == "U") || (c == "l") || (c == "L")) begin
      r.s.mode = M_SUFFIX;
      r.s      = f_take(r.s, c);
      r.used   = 2'd1;
    end else begin
      r.emit   = 1'b1;
      r.kind   = s.flt ? K_FLOAT : K_INT;
      r.s.flt  = 1'b0;
      r.s.mode = M_IDLE;
    end
    return r;
  endfunction

  // One byte inside a token or comment.
  function automatic mr_t f_absorb(sc_t s, logic [7:0] c);
    mr_t  r;
    logic eat;
    r.s = s; r.used = 2'd0; r.emit = 1'b0; r.kind = K_IDENT;
    eat = 1'b0;
    case (s.mode)
      M_IDENT: begin
        if (id_cont(c)) begin
          eat = 1'b1;
        end else begin
          r.emit   = 1'b1;
          r.kind   = K_IDENT;
          r.s.mode = M_IDLE;
        end
      end
      M_HEX: begin
        if (is_xdigit(c)) eat = 1'b1;
        else r = f_suffix(s, c);
      end
      M_INT, M_FRAC: begin
        if (is_digit(c)) begin
          eat = 1'b1;
        end else if ((c == ".") && (s.mode == M_INT)) begin
          r.s.flt  = 1'b1;
          r.s.mode = M_FRAC;
          eat      = 1'b1;
        end else if ((c == "e") || (c == "E")) begin
          r.s.flt  = 1'b1;
          r.s.mode = M_EXPS;
          eat      = 1'b1;
        end else begin
          r = f_suffix(s, c);
        end
      end
      M_EXPS: begin
        if ((c == "+") || (c == "-") || is_digit(c)) begin
          r.s.mode = M_EXPD;
          eat      = 1'b1;
        end else begin
          r = f_suffix(s, c);
        end
      end
      M_EXPD: begin
        if (is_digit(c)) eat = 1'b1;
        else r = f_suffix(s, c);
      end
      M_SUFFIX: begin
        r = f_suffix(s, c);
      end
      M_STR, M_CHR: begin
        eat = 1'b1;
        if (s.esc) begin
          r.s.esc = 1'b0;
        end else if (c == CH_BSLASH) begin
          r.s.esc = 1'b1;
        end else if (c == ((s.mode == M_STR) ? CH_DQUOTE : CH_SQUOTE)) begin
          r.emit   = 1'b1;
          r.kind   = (s.mode == M_STR) ? K_STRING : K_CHAR;
          r.s.mode = M_IDLE;
        end
      end
      M_LINE: begin
        // The newline ends the line but is left for the idle decision.
        if (c == CH_NL) r.s.mode = M_IDLE;
        else eat = 1'b1;
      end
      M_BLOCK: begin
        eat = 1'b1;
        if (s.star && (c == "/")) begin
          r.s.flt  = 1'b0;
          r.s.star = 1'b0;
          r.s.mode = M_IDLE;
        end else begin
          r.s.flt  = 1'b0;
          r.s.star = (c == "*");
        end
      end
      default: begin
        r.s.mode = M_IDLE;
      end
    endcase
    if (eat) begin
      r.s    = f_take(r.s, c);
      r.used = 2'd1;
    end
    return r;
  endfunction

  // Start of a token or of skipped text, with up to two bytes of lookahead.
  function automatic mr_t f_decide(sc_t s, logic [7:0] a, logic [7:0] b, logic bv,
                                   logic [7:0] d, logic dv);
    mr_t        r;
    logic       hit;
    logic       len3;
    logic [4:0] hidx;
    logic [5:0] sk;
    r.s = s; r.used = 2'd0; r.emit = 1'b0; r.kind = K_IDENT;
    hit = 1'b0; len3 = 1'b0; hidx = '0; sk = K_UNKNOWN;
    for (int i = N_MULTI - 1; i >= 0; i--) begin
      if ((a == MULTI_OPS[i][23:16]) && bv && (b == MULTI_OPS[i][15:8]) &&
          ((MULTI_OPS[i][7:0] == CH_NUL) || (dv && (d == MULTI_OPS[i][7:0])))) begin
        hit  = 1'b1;
        hidx = 5'(i);
        len3 = (MULTI_OPS[i][7:0] != CH_NUL);
      end
    end
    for (int i = N_SINGLE - 1; i >= 0; i--) begin
      if (a == SINGLE_OPS[i]) sk = K_SINGLE_BASE + 6'(i);
    end

    if ((a == CH_SPACE) || (a == CH_TAB) || (a == CH_CR) || (a == CH_NL)) begin
      r.s = f_take(s, a); r.used = 2'd1;
    end else if ((a == "/") && bv && ((b == "/") || (b == "*"))) begin
      r.s      = f_take(f_take(s, a), b);
      r.used   = 2'd2;
      r.s.mode = (b == "/") ? M_LINE : M_BLOCK;
      r.s.flt  = 1'b0;
      r.s.star = 1'b0;
    end else if ((a == "#") && ((s.col == POS_W'(1)) || !s.any)) begin
      r.s      = f_take(s, a);
      r.used   = 2'd1;
      r.s.mode = M_LINE;
    end else begin
      r.s.tb = s.off; r.s.tl = s.line; r.s.tc = s.col;
      if (id_start(a)) begin
        r.s      = f_take(r.s, a);
        r.used   = 2'd1;
        r.s.mode = M_IDENT;
      end else if (is_digit(a) || ((a == ".") && bv && is_digit(b))) begin
        r.s.flt  = 1'b0;
        r.s.star = 1'b0;
        if ((a == "0") && bv && ((b == "x") || (b == "X"))) begin
          r.s      = f_take(f_take(r.s, a), b);
          r.used   = 2'd2;
          r.s.mode = M_HEX;
        end else if (a == ".") begin
          r.s      = f_take(r.s, a);
          r.used   = 2'd1;
          r.s.flt  = 1'b1;
          r.s.mode = M_FRAC;
        end else begin
          r.s      = f_take(r.s, a);
          r.used   = 2'd1;
          r.s.mode = M_INT;
        end
      end else if ((a == CH_DQUOTE) || (a == CH_SQUOTE)) begin
        r.s      = f_take(r.s, a);
        r.used   = 2'd1;
        r.s.esc  = 1'b0;
        r.s.mode = (a == CH_DQUOTE) ? M_STR : M_CHR;
      end else if (hit) begin
        r.s    = f_take(f_take(r.s, a), b);
        r.used = 2'd2;
        if (len3) begin
          r.s    = f_take(r.s, d);
          r.used = 2'd3;
        end
        r.emit = 1'b1;
        r.kind = K_MULTI_BASE + 6'(hidx);
      end else begin
        r.s    = f_take(r.s, a);
        r.used = 2'd1;
        r.emit = 1'b1;
        r.kind = sk;
      end
    end
    return r;
  endfunction

  sc_t        sc_r, sc_nxt;
  logic [7:0] held0_r, held0_nxt;
  logic [7:0] held1_r, held1_nxt;
  logic [1:0] hcnt_r, hcnt_nxt;

  always_comb begin
    sc_t                  s;
    mr_t                  m;
    logic [7:0]           w [8];
    logic [2:0]           n;
    logic [2:0]           idx;
    logic [2:0]           rem;
    logic [1:0]           hc;
    logic                 stop;
    logic                 fe;
    logic [5:0]           fk;
    logic [RES_CNT_W-1:0] nres;
    rec_t [RES_MAX-1:0]   res;

    hc = (hcnt_r > 2'd2) ? 2'd2 : hcnt_r;
    for (int i = 0; i < 8; i++) w[i] = '0;
    if (hc != 2'd0) w[0] = held0_r;
    if (hc == 2'd2) w[1] = held1_r;
    if (!end_marker) w[3'(hc)] = data_byte;
    n = 3'(hc) + (end_marker ? 3'd0 : 3'd1);

    s = sc_r; idx = '0; stop = 1'b0; nres = '0; res = '0; m = '0;
    fe = 1'b0; fk = K_IDENT;

    // Between tokens a decision waits for three visible bytes unless the
    // source has ended; three actions cover every window.
    for (int it = 0; it < 3; it++) begin
      if (!stop && (idx < n)) begin
        if ((s.mode == M_IDLE) && ((n - idx) < 3'd3) && !end_marker) begin
          stop = 1'b1;
        end else begin
          if (s.mode == M_IDLE) begin
            m = f_decide(s, w[idx], w[idx + 3'd1], (idx + 3'd1) < n,
                         w[idx + 3'd2], (idx + 3'd2) < n);
          end else begin
            m = f_absorb(s, w[idx]);
          end
          s   = m.s;
          idx = idx + 3'(m.used);
          if (m.emit && (nres != RES_CNT_W'(RES_MAX))) begin
            res[nres] = f_rec(m.kind, s);
            nres      = nres + RES_CNT_W'(1);
            s.any     = 1'b1;
          end
        end
      end
    end

    rem = n - idx;
    held0_nxt = w[idx];
    held1_nxt = w[idx + 3'd1];
    hcnt_nxt  = (rem > 3'd2) ? 2'd2 : rem[1:0];
    sc_nxt    = s;

    if (end_marker) begin
      // Close whatever is open, then report End at the final position.
      case (s.mode)
        M_IDENT: begin
          fe = 1'b1; fk = K_IDENT;
        end
        M_HEX, M_INT, M_FRAC, M_EXPS, M_EXPD, M_SUFFIX: begin
          fe = 1'b1; fk = s.flt ? K_FLOAT : K_INT;
        end
        M_STR: begin
          fe = 1'b1; fk = K_STRING;
        end
        M_CHR: begin
          fe = 1'b1; fk = K_CHAR;
        end
        default: begin
          fe = 1'b0;
        end
      endcase
      if (fe && (nres != RES_CNT_W'(RES_MAX))) begin
        res[nres] = f_rec(fk, s);
        nres      = nres + RES_CNT_W'(1);
      end
      s.tb = s.off; s.tl = s.line; s.tc = s.col;
      if (nres != RES_CNT_W'(RES_MAX)) begin
        res[nres] = f_rec(K_END, s);
        nres      = nres + RES_CNT_W'(1);
      end
      sc_nxt    = SC_RESET;
      held0_nxt = '0;
      held1_nxt = '0;
      hcnt_nxt  = '0;
    end

    if (nres != '0) res[nres - RES_CNT_W'(1)].run_last = 1'b1;
    burst.cnt = nres;
    burst.rec = res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r    <= SC_RESET;
      held0_r <= '0;
      held1_r <= '0;
      hcnt_r  <= '0;
    end else if (step) begin
      sc_r    <= sc_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      hcnt_r  <= hcnt_nxt;
    end
  end

endmodule

### rtl/ctl_out_q.sv
// Result queue: takes a burst of up to three tokens per cycle, hands out one.
// Depends on ctl_pkg for the record and burst types and the queue depth.
module ctl_out_q (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push_en,
  input  ctl_pkg::burst_t           push,
  input  logic                      pop,
  output ctl_pkg::rec_t             head,
  output logic [ctl_pkg::Q_CNT_W-1:0] count
);
  import ctl_pkg::*;

  rec_t                 mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic [RES_CNT_W-1:0] push_n;

  assign push_n = push_en ? push.cnt : '0;

  always_ff @(posedge clk) begin
    for (int j = 0; j < RES_MAX; j++) begin
      if (RES_CNT_W'(j) < push_n) mem_r[wr_ptr_r + Q_PTR_W'(j)] <= push.rec[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + Q_PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + Q_PTR_W'(pop);
      cnt_r    <= cnt_r + Q_CNT_W'(push_n) - Q_CNT_W'(pop);
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign count = cnt_r;

endmodule

### rtl/c_token_lexer.sv
// Top level of the streaming C token lexer.
// Depends on ctl_pkg, ctl_scanner and ctl_out_q.
//
// Usage: source bytes enter one word per cycle on the in_ channel while
// in_stall is low. A word with in_end_marker set carries no byte; it closes
// any open token, emits End and returns the lexer to its reset state so
// that a new source can follow at once. Tokens leave on the out_ channel,
// one word per token, with kind, byte span, and start line and column;
// out_run_last marks the last token caused by a given input word.
// Throughput: one input word per cycle while the result side keeps up; a
// word yields at most three tokens, and the output queue drains one a
// cycle while out_stall is low. Path: an accepted word waits in the input
// register; the tokens it completes enter the queue whose head drives out_.
// Between tokens the scanner decides only when it sees three bytes, so a
// token can complete up to two words after its last byte, and never later
// than the end marker.
// Reset: synchronous, active low. It empties the queue and returns the
// scanner to line 1, column 1, offset 0.
// Stall: when out_stall holds the queue fills; in_stall rises as soon as
// fewer than two bursts of room remain, so no token is ever dropped.
module c_token_lexer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_end_marker,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [5:0]                 out_token_kind,
  output logic [ctl_pkg::POS_W-1:0]  out_span_begin,
  output logic [ctl_pkg::POS_W-1:0]  out_span_end,
  output logic [ctl_pkg::POS_W-1:0]  out_start_line,
  output logic [ctl_pkg::POS_W-1:0]  out_start_column,
  output logic                       out_run_last
);
  import ctl_pkg::*;

  // Input register: one word waits here for the scanner step.
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;

  burst_t             burst;
  rec_t               head;
  logic [Q_CNT_W-1:0] q_count;
  logic               pop;

  // Room is reserved for the word in the input register and for the one
  // being accepted, so the scanner never has to wait.
  assign in_stall = (q_count > Q_CNT_W'(Q_DEPTH - 2 * RES_MAX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_data_byte;
      in_end_r  <= in_end_marker;
    end
  end

  ctl_scanner u_scanner (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_vld_r),
    .data_byte  (in_byte_r),
    .end_marker (in_end_r),
    .burst      (burst)
  );

  ctl_out_q u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_en (in_vld_r),
    .push    (burst),
    .pop     (pop),
    .head    (head),
    .count   (q_count)
  );

  assign out_valid        = (q_count != '0);
  assign pop              = out_valid && !out_stall;
  assign out_token_kind   = head.token_kind;
  assign out_span_begin   = head.span_begin;
  assign out_span_end     = head.span_end;
  assign out_start_line   = head.start_line;
  assign out_start_column = head.start_column;
  assign out_run_last     = head.run_last;

  // A word in the input register always finds room for its whole burst.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |-> (q_count <= Q_CNT_W'(Q_DEPTH - RES_MAX)))
    else $error("queue lacks room for a pending burst");

  // The queue never holds more than its depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overflow");

  // An end marker always produces at least the End token.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && in_end_r) |-> (burst.cnt != '0))
    else $error("end marker produced no token");

  // A burst of tokens from the scanner makes out_valid high in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && (burst.cnt != '0)) |=> out_valid)
    else $error("produced tokens did not reach the output");

endmodule
